[src/urxf_pkg.sv]
// Shared types and constants of the serial receive FIFO with statistics.
// No dependencies; used by urxf_ctrl, urxf_dpath and the top level.
package urxf_pkg;

  // Field widths fixed by the stream payload layout.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffsetW  = 6;
  localparam int unsigned LevelW   = 6;
  localparam int unsigned CntW     = 16;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 64;

  // Command carried in the input tuser.
  typedef enum logic [CmdW-1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_POP     = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_FLUSH   = 2'd3
  } cmd_e;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // input transfer: update state, start the memory access
    logic load;  // capture the result into the output register
  } ctrl_cmd_t;

endpackage

[src/urxf_ctrl.sv]
// Controller of the receive FIFO: sequences accept, execute and result load.
// Depends on urxf_pkg.
module urxf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output urxf_pkg::ctrl_cmd_t  cmd_o
);

  urxf_pkg::state_e state_q, state_d;
  logic             ov_q, ov_d;

  always_comb begin
    state_d    = state_q;
    ov_d       = ov_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      urxf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = urxf_pkg::ST_EXEC;
        end
      end
      urxf_pkg::ST_EXEC: begin
        // The result register is free or is being emptied this cycle.
        if (!ov_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          ov_d       = 1'b1;
          state_d    = urxf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = urxf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urxf_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[src/urxf_dpath.sv]
// Datapath of the receive FIFO: byte ring memory, pointers, counters, result register.
// Depends on urxf_pkg.
module urxf_dpath #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  urxf_pkg::ctrl_cmd_t               cmd_i,
  input  urxf_pkg::cmd_e                    op_i,
  input  logic [urxf_pkg::ByteW-1:0]        line_byte_i,
  input  logic                              framing_bad_i,
  input  logic [urxf_pkg::OffsetW-1:0]      peek_offset_i,
  output logic [urxf_pkg::OutDataW-1:0]     result_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned CW = (PW > urxf_pkg::OffsetW) ? PW : urxf_pkg::OffsetW;

  logic [urxf_pkg::ByteW-1:0] mem [RING_DEPTH];

  logic [PW-1:0]                 wp_q, wp_d, rp_q, rp_d;
  logic [urxf_pkg::CntW-1:0]     good_q, good_d, ovf_q, ovf_d, bad_q, bad_d;
  logic [urxf_pkg::ByteW-1:0]    rd_q;
  logic                          hit_q;
  logic [urxf_pkg::OutDataW-1:0] res_q;

  logic [PW-1:0]   fill, wp_next, rp_next, peek_addr, raddr;
  logic [CW-1:0]   fill_ext;
  logic [CW:0]     peek_sum;
  logic            full, empty, peek_hit, hit, do_write;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Fill level modulo the ring depth; the depth need not be a power of two.
  always_comb begin
    if (wp_q >= rp_q) begin
      fill = wp_q - rp_q;
    end else begin
      fill = PW'({1'b0, wp_q} + ((PW+1)'(RING_DEPTH) - {1'b0, rp_q}));
    end
  end

  assign fill_ext = CW'(fill);
  assign wp_next  = ptr_inc(wp_q);
  assign rp_next  = ptr_inc(rp_q);
  assign full     = (wp_next == rp_q);
  assign empty    = (wp_q == rp_q);
  assign peek_hit = (CW'(peek_offset_i) < fill_ext);

  // A hit offset is below the fill level, so the sum stays under twice the depth.
  always_comb begin
    peek_sum = (CW+1)'(rp_q) + (CW+1)'(peek_offset_i);
    if (peek_sum >= (CW+1)'(RING_DEPTH)) begin
      peek_sum = peek_sum - (CW+1)'(RING_DEPTH);
    end
    peek_addr = PW'(peek_sum);
  end

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    good_d   = good_q;
    ovf_d    = ovf_q;
    bad_d    = bad_q;
    hit      = 1'b0;
    do_write = 1'b0;
    raddr    = peek_addr;
    case (op_i)
      urxf_pkg::CMD_RECEIVE: begin
        if (framing_bad_i) begin
          bad_d = bad_q + 1'b1;
        end else if (full) begin
          ovf_d = ovf_q + 1'b1;
        end else begin
          do_write = 1'b1;
          wp_d     = wp_next;
          good_d   = good_q + 1'b1;
        end
      end
      urxf_pkg::CMD_POP: begin
        raddr = rp_q;
        if (!empty) begin
          hit  = 1'b1;
          rp_d = rp_next;
        end
      end
      urxf_pkg::CMD_PEEK: begin
        hit = peek_hit;
      end
      urxf_pkg::CMD_FLUSH: begin
        wp_d = '0;
        rp_d = '0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      good_q <= '0;
      ovf_q  <= '0;
      bad_q  <= '0;
    end else if (cmd_i.take) begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      good_q <= good_d;
      ovf_q  <= ovf_d;
      bad_q  <= bad_d;
    end
  end

  // Ring memory: at most one write and one registered read per item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && do_write) begin
      mem[wp_q] <= line_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_q  <= mem[raddr];
      hit_q <= hit;
    end
  end

  // Pointers and counters already hold their post-item values here.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= {1'b0, bad_q, ovf_q, good_q,
                urxf_pkg::LevelW'(fill_ext), hit_q,
                hit_q ? rd_q : {urxf_pkg::ByteW{1'b0}}};
    end
  end

  assign result_o = res_q;

endmodule

[src/uart_rx_fifo_with_stats_core.sv]
// Top level of the serial receive FIFO with statistics counters.
// Depends on urxf_pkg, urxf_ctrl and urxf_dpath.
//
// Usage: every input transfer carries one command in s_tuser_i (receive,
// pop, peek, flush) and yields exactly one result transfer on the master
// side. The result reports the byte popped or peeked with its valid flag,
// the fill level after the command and the accepted, dropped and
// framing-error counters, which wrap at 16 bits.
// The ring holds at most RING_DEPTH-1 bytes; one slot always stays empty.
// m_tvalid_o rises once the execute state has loaded the result register;
// that load waits while an earlier result is still held.
// The input transfer cycle updates pointers and counters and issues the
// ring memory access; its registered read data is captured into the result
// register in the execute state, and only then is the next input taken.
// A held result does not stop the next input transfer; that item then
// waits in execution until the result register has been emptied.
// Reset clears pointers, counters and the handshake state; the memory
// needs no clearing since read data is only passed on for written slots.
module uart_rx_fifo_with_stats_core #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // Bits from low: line_byte[7:0], framing_bad[8], peek_offset[14:9], zero[15].
  input  logic [urxf_pkg::InDataW-1:0]      s_tdata_i,
  // Bits from low: command[1:0].
  input  logic [urxf_pkg::CmdW-1:0]         s_tuser_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // Bits from low: read_data[7:0], read_valid[8], bytes_available[14:9],
  // accepted_count[30:15], dropped_count[46:31], framing_error_count[62:47],
  // zero[63].
  output logic [urxf_pkg::OutDataW-1:0]     m_tdata_o
);

  urxf_pkg::ctrl_cmd_t ctrl_cmd;

  urxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .cmd_o       (ctrl_cmd)
  );

  urxf_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .op_i          (urxf_pkg::cmd_e'(s_tuser_i)),
    .line_byte_i   (s_tdata_i[7:0]),
    .framing_bad_i (s_tdata_i[8]),
    .peek_offset_i (s_tdata_i[14:9]),
    .result_o      (m_tdata_o)
  );

`ifndef SYNTHESIS
  // An input transfer is always followed by a cycle in which no input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input taken while the previous item is still executing");

  // A result without a byte carries zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tdata_o[8]) |-> (m_tdata_o[7:0] == 8'd0))
    else $error("read data nonzero without read valid");

  // The controller never takes an item and loads a result in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_cmd.take && ctrl_cmd.load))
    else $error("take and load issued together");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for uart_rx_fifo_with_stats_core.
// Depends on urxf_pkg and the RTL; a clocked driver, a clocked monitor and
// a shadow ring with counters that predicts every result transfer.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RingDepth  = 64;
  localparam int unsigned CycleLimit = 200000;

  // One input transfer as the stream carries it.
  typedef struct packed {
    urxf_pkg::cmd_e                 cmd;
    logic [urxf_pkg::ByteW-1:0]     line_byte;
    logic                           framing_bad;
    logic [urxf_pkg::OffsetW-1:0]   peek_offset;
  } rx_item_t;

  // One result transfer, unpacked; the last member sits in the lowest bits.
  typedef struct packed {
    logic [urxf_pkg::CntW-1:0]   framing_error_count;
    logic [urxf_pkg::CntW-1:0]   dropped_count;
    logic [urxf_pkg::CntW-1:0]   accepted_count;
    logic [urxf_pkg::LevelW-1:0] bytes_available;
    logic                        read_valid;
    logic [urxf_pkg::ByteW-1:0]  read_data;
  } fifo_result_t;

  // Command mix of a stretch of random traffic.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_tvalid;
  logic                          s_tready_o;
  logic [urxf_pkg::InDataW-1:0]  s_tdata;
  logic [urxf_pkg::CmdW-1:0]     s_tuser;
  logic                          m_tvalid_o;
  logic                          m_tready;
  logic [urxf_pkg::OutDataW-1:0] m_tdata_o;

  rx_item_t     pending_items[$];
  fifo_result_t expected_results[$];

  // Shadow state of the ring and its statistics.
  logic [urxf_pkg::ByteW-1:0] shadow_ring [RingDepth];
  int unsigned                shadow_wr_ptr;
  int unsigned                shadow_rd_ptr;
  logic [urxf_pkg::CntW-1:0]  shadow_good;
  logic [urxf_pkg::CntW-1:0]  shadow_dropped;
  logic [urxf_pkg::CntW-1:0]  shadow_bad_frames;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  uart_rx_fifo_with_stats_core #(
    .RING_DEPTH(RingDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Fill level of the shadow ring.
  function automatic int unsigned shadow_level();
    return (RingDepth + shadow_wr_ptr - shadow_rd_ptr) % RingDepth;
  endfunction

  // Applies one accepted command to the shadow state and queues the result
  // that the block must return for it.
  task automatic predict_fifo(input rx_item_t it);
    fifo_result_t res;
    int unsigned  next_wr;
    res = '0;
    case (it.cmd)
      urxf_pkg::CMD_RECEIVE: begin
        if (it.framing_bad) begin
          shadow_bad_frames = shadow_bad_frames + 1'b1;
        end else begin
          next_wr = (shadow_wr_ptr + 1) % RingDepth;
          if (next_wr != shadow_rd_ptr) begin
            shadow_ring[shadow_wr_ptr] = it.line_byte;
            shadow_wr_ptr = next_wr;
            shadow_good = shadow_good + 1'b1;
          end else begin
            shadow_dropped = shadow_dropped + 1'b1;
          end
        end
      end
      urxf_pkg::CMD_POP: begin
        if (shadow_wr_ptr != shadow_rd_ptr) begin
          res.read_data  = shadow_ring[shadow_rd_ptr];
          res.read_valid = 1'b1;
          shadow_rd_ptr  = (shadow_rd_ptr + 1) % RingDepth;
        end
      end
      urxf_pkg::CMD_PEEK: begin
        if (it.peek_offset < shadow_level()) begin
          res.read_data  = shadow_ring[(shadow_rd_ptr + it.peek_offset) % RingDepth];
          res.read_valid = 1'b1;
        end
      end
      default: begin
        shadow_wr_ptr = 0;
        shadow_rd_ptr = 0;
      end
    endcase
    res.bytes_available     = urxf_pkg::LevelW'(shadow_level());
    res.accepted_count      = shadow_good;
    res.dropped_count       = shadow_dropped;
    res.framing_error_count = shadow_bad_frames;
    expected_results.push_back(res);
  endtask

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what, input logic [urxf_pkg::CntW-1:0] got,
                                 input logic [urxf_pkg::CntW-1:0] want);
    $display("ERROR cycle %0d: %s is 0x%0h, expected 0x%0h", cycle_count, what, got,
             want);
    mismatch_count++;
  endtask

  task automatic compare_field(input string what, input logic [urxf_pkg::CntW-1:0] got,
                               input logic [urxf_pkg::CntW-1:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic queue_item(input urxf_pkg::cmd_e cmd,
                            input logic [urxf_pkg::ByteW-1:0] line_byte,
                            input logic framing_bad,
                            input logic [urxf_pkg::OffsetW-1:0] offset);
    rx_item_t it;
    it.cmd         = cmd;
    it.line_byte   = line_byte;
    it.framing_bad = framing_bad;
    it.peek_offset = offset;
    pending_items.push_back(it);
  endtask

  // Random command with random content; the mix decides how the ring level
  // drifts, so that stretches of fill traffic reach the full ring.
  task automatic queue_random_item(input traffic_mix_e mix);
    int unsigned                  roll;
    int unsigned                  recv_lim;
    int unsigned                  pop_lim;
    urxf_pkg::cmd_e               cmd;
    logic [urxf_pkg::OffsetW-1:0] offset;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin recv_lim = 84; pop_lim = 89; end
      MIX_DRAIN: begin recv_lim = 25; pop_lim = 83; end
      default:   begin recv_lim = 35; pop_lim = 65; end
    endcase
    if (roll < recv_lim)      cmd = urxf_pkg::CMD_RECEIVE;
    else if (roll < pop_lim)  cmd = urxf_pkg::CMD_POP;
    else if (roll < 98)       cmd = urxf_pkg::CMD_PEEK;
    else                      cmd = urxf_pkg::CMD_FLUSH;
    // Offsets near the top are only in range when the ring is nearly full.
    if ($urandom_range(99) < 40) offset = urxf_pkg::OffsetW'($urandom_range(62, 50));
    else                         offset = urxf_pkg::OffsetW'($urandom_range(62, 0));
    queue_item(cmd, urxf_pkg::ByteW'($urandom_range(255)), $urandom_range(99) < 12,
               offset);
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || expected_results.size() != 0 || s_tvalid) begin
      @(posedge clk_i);
    end
  endtask

  // Driver: presents pending items on the slave side. An accepted transfer
  // updates the prediction at the edge where it happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready_o) begin
        predict_fifo(pending_items.pop_front());
      end
      if (!s_tvalid || s_tready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, pending_items[0].peek_offset, pending_items[0].framing_bad,
                       pending_items[0].line_byte};
          s_tuser  <= pending_items[0].cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest expectation and
  // stalls the master side at random.
  always @(posedge clk_i) begin
    fifo_result_t got;
    fifo_result_t want;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready) begin
        got = m_tdata_o[62:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, tdata[15:0]", m_tdata_o[15:0],
                          '0);
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", got.read_data, want.read_data);
          compare_field("read_valid", got.read_valid, want.read_valid);
          compare_field("bytes_available", got.bytes_available, want.bytes_available);
          compare_field("accepted_count", got.accepted_count, want.accepted_count);
          compare_field("dropped_count", got.dropped_count, want.dropped_count);
          compare_field("framing_error_count", got.framing_error_count,
                        want.framing_error_count);
          compare_field("tdata padding bit", m_tdata_o[63], 1'b0);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    traffic_mix_e mix;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    s_tvalid          = 1'b0;
    s_tdata           = '0;
    s_tuser           = urxf_pkg::CMD_RECEIVE;
    m_tready          = 1'b0;
    cycle_count       = 0;
    mismatch_count    = 0;
    shadow_wr_ptr     = 0;
    shadow_rd_ptr     = 0;
    shadow_good       = '0;
    shadow_dropped    = '0;
    shadow_bad_frames = '0;
    for (n = 0; n < RingDepth; n++) shadow_ring[n] = '0;
    send_idle_pct     = 11;
    recv_idle_pct     = 76;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty ring, byte extremes, framing errors, peeks in and out
    // of range, pop down to empty, and flush both with data and when empty.
    queue_item(urxf_pkg::CMD_POP,     8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_PEEK,    8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'hFF, 1'b1, 6'd62);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'hFF, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'hA5, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'h5A, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_PEEK,    8'hFF, 1'b1, 6'd0);
    queue_item(urxf_pkg::CMD_PEEK,    8'h00, 1'b0, 6'd3);
    queue_item(urxf_pkg::CMD_PEEK,    8'h00, 1'b0, 6'd4);
    queue_item(urxf_pkg::CMD_PEEK,    8'h00, 1'b0, 6'd62);
    queue_item(urxf_pkg::CMD_POP,     8'hFF, 1'b1, 6'd62);
    queue_item(urxf_pkg::CMD_POP,     8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_FLUSH,   8'hFF, 1'b1, 6'd62);
    queue_item(urxf_pkg::CMD_POP,     8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_PEEK,    8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'h81, 1'b1, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'h7E, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_POP,     8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_POP,     8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_FLUSH,   8'h00, 1'b0, 6'd0);
    queue_item(urxf_pkg::CMD_RECEIVE, 8'h3C, 1'b0, 6'd0);

    // Random traffic in stretches of one mix, over three pacing phases.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 11; recv_idle_pct = 76; end
        1:       begin send_idle_pct = 76; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      mix = MIX_FILL;
      for (n = 0; n < 630; n++) begin
        if (n % 70 == 0) begin
          mix = traffic_mix_e'($urandom_range(2));
        end
        queue_random_item(mix);
      end
      wait_for_drain();
    end

    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/urxf_pkg.sv
src/urxf_ctrl.sv
src/urxf_dpath.sv
src/uart_rx_fifo_with_stats_core.sv
tb/tb_top.sv
